// ===== design/hct_pkg.sv =====
// Shared types and constants for the handheld console timer.
// Used by hct_timer, handheld_console_timer_core and the testbench; no dependencies.
package hct_pkg;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    localparam logic [7:0] NO_RELOAD     = 8'hFF;
    localparam logic [7:0] RELOAD_CYCLES = 8'd4;
    localparam logic [7:0] COUNTER_MAX   = 8'hFF;

    typedef enum logic [1:0] {
        REG_DIV  = 2'd0,
        REG_CNT  = 2'd1,
        REG_MOD  = 2'd2,
        REG_CTRL = 2'd3
    } t_reg_idx;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic       step;
        logic       wr_en;
        t_reg_idx   idx;
        logic [7:0] data;
    } t_tmr_cmd;

    // Returns the divider bit whose falling edge clocks the counter.
    function automatic logic sel_div_bit(input logic [15:0] div, input logic [1:0] sel);
        logic b;
        case (sel)
            2'd0:    b = div[9];
            2'd1:    b = div[3];
            2'd2:    b = div[5];
            default: b = div[7];
        endcase
        return b;
    endfunction

endpackage

// ===== design/handheld_console_timer_core.sv =====
// Handheld console timer core: stream handshake, tick sequencer and result register.
// Reads, writes, halted or empty ticks: result registered in the cycle after the input transfer.
// A tick of N machine cycles (N capped at MAX_TICKS_PER_ITEM) steps the shared timer
// unit once per clock; no new item is accepted until that run has finished.
// Synchronous active-low reset clears all timer state and marks no reload pending.
// Depends on hct_pkg and hct_timer.
module handheld_console_timer_core
    import hct_pkg::*;
#(
    parameter int MAX_TICKS_PER_ITEM = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // reg_index[1:0], write_data[9:2], tick_count[15:10],
                                       // halted[16], zero fill
    input  logic [1:0]  s_axis_tuser,  // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // read_data[7:0], timer_irq[8], zero fill
);

    localparam int CW = $clog2(MAX_TICKS_PER_ITEM + 1);
    localparam int EW = (CW > 6) ? CW : 6;

    t_state      r_state, n_state;
    logic [CW-1:0] r_left, n_left;
    logic        r_irq, n_irq;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_rd, n_out_rd;
    logic        r_out_irq, n_out_irq;

    logic        accept;
    logic [1:0]  in_kind;
    t_reg_idx    in_idx;
    logic [7:0]  in_data;
    logic [EW-1:0] in_count;
    logic        in_halted;
    logic [CW-1:0] sat_count;
    logic        start_run;
    logic        run_done;
    t_tmr_cmd    cmd;
    logic [7:0]  tmr_rd;
    logic        tmr_irq;

    assign in_idx    = t_reg_idx'(s_axis_tdata[1:0]);
    assign in_data   = s_axis_tdata[9:2];
    assign in_count  = EW'(s_axis_tdata[15:10]);
    assign in_halted = s_axis_tdata[16];
    assign in_kind   = s_axis_tuser;

    assign sat_count = (in_count > EW'(MAX_TICKS_PER_ITEM)) ? CW'(MAX_TICKS_PER_ITEM)
                                                             : CW'(in_count);

    assign s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign start_run     = accept && in_kind == KIND_TICK && !in_halted
                           && sat_count != '0;
    assign run_done      = (r_state == ST_RUN) && (r_left == CW'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start_run) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (run_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.idx     = in_idx;
        cmd.data    = in_data;
        n_left      = r_left;
        n_irq       = r_irq;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_rd    = r_out_rd;
        n_out_irq   = r_out_irq;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    cmd.wr_en = (in_kind == KIND_WRITE);
                    n_left    = sat_count;
                    n_irq     = 1'b0;
                    if (!start_run) begin
                        n_out_valid = 1'b1;
                        n_out_rd    = (in_kind == KIND_READ) ? tmr_rd : 8'd0;
                        n_out_irq   = tmr_irq;
                    end
                end
            end
            ST_RUN: begin
                cmd.step = 1'b1;
                n_left   = r_left - CW'(1);
                n_irq    = r_irq | tmr_irq;
                if (run_done) begin
                    n_out_valid = 1'b1;
                    n_out_rd    = 8'd0;
                    n_out_irq   = r_irq | tmr_irq;
                end
            end
            default: ;
        endcase
    end

    hct_timer u_timer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_rd_idx  (in_idx),
        .o_rd_data (tmr_rd),
        .o_irq     (tmr_irq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_left      <= '0;
            r_irq       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_left      <= n_left;
            r_irq       <= n_irq;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_rd  <= n_out_rd;
        r_out_irq <= n_out_irq;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_irq, r_out_rd};

endmodule

// ===== design/hct_timer.sv =====
// Timer state and the shared per-cycle step unit: divider, counter, reload delay.
// Depends on hct_pkg; driven one command per cycle by the core sequencer.
module hct_timer
    import hct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_tmr_cmd   i_cmd,
    input  t_reg_idx   i_rd_idx,
    output logic [7:0] o_rd_data,
    output logic       o_irq
);

    logic [15:0] r_div,   n_div;
    logic [7:0]  r_cnt,   n_cnt;
    logic [7:0]  r_mod,   n_mod;
    logic        r_en,    n_en;
    logic [1:0]  r_sel,   n_sel;
    logic [7:0]  r_delay, n_delay;

    logic [15:0] div_inc;
    logic [7:0]  cnt_pre;
    logic [7:0]  delay_pre;
    logic [7:0]  delay_dec;
    logic        fall;

    always_comb begin
        n_div     = r_div;
        n_cnt     = r_cnt;
        n_mod     = r_mod;
        n_en      = r_en;
        n_sel     = r_sel;
        n_delay   = r_delay;
        o_irq     = 1'b0;
        div_inc   = r_div + 16'd1;
        delay_dec = r_delay - 8'd1;
        cnt_pre   = r_cnt;
        delay_pre = r_delay;
        fall      = 1'b0;

        if (i_cmd.step) begin
            if (r_delay != NO_RELOAD) begin
                delay_pre = delay_dec;
                if (delay_dec == 8'd0) begin
                    cnt_pre   = r_mod;
                    delay_pre = NO_RELOAD;
                end
            end
            fall  = sel_div_bit(r_div, r_sel) & ~sel_div_bit(div_inc, r_sel);
            n_div = div_inc;
        end else if (i_cmd.wr_en && i_cmd.idx == REG_DIV) begin
            fall  = sel_div_bit(r_div, r_sel);
            n_div = 16'd0;
        end

        n_cnt   = cnt_pre;
        n_delay = delay_pre;
        if (r_en && fall) begin
            if (cnt_pre == COUNTER_MAX) begin
                n_cnt   = 8'd0;
                n_delay = RELOAD_CYCLES;
                o_irq   = 1'b1;
            end else begin
                n_cnt = cnt_pre + 8'd1;
            end
        end

        if (i_cmd.wr_en) begin
            unique case (i_cmd.idx)
                REG_CNT: begin
                    if (r_delay != 8'd0) begin
                        n_cnt = i_cmd.data;
                    end
                end
                REG_MOD:  n_mod = i_cmd.data;
                REG_CTRL: begin
                    n_en  = i_cmd.data[2];
                    n_sel = i_cmd.data[1:0];
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_rd_idx)
            REG_DIV:  o_rd_data = r_div[15:8];
            REG_CNT:  o_rd_data = r_cnt;
            REG_MOD:  o_rd_data = r_mod;
            default:  o_rd_data = {5'd0, r_en, r_sel};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div   <= 16'd0;
            r_cnt   <= 8'd0;
            r_mod   <= 8'd0;
            r_en    <= 1'b0;
            r_sel   <= 2'd0;
            r_delay <= NO_RELOAD;
        end else begin
            r_div   <= n_div;
            r_cnt   <= n_cnt;
            r_mod   <= n_mod;
            r_en    <= n_en;
            r_sel   <= n_sel;
            r_delay <= n_delay;
        end
    end

endmodule

// ===== tb/sv/hct_reply_checker.sv =====
// Checker for the handheld console timer: watches both stream channels, predicts
// each reply from its own copy of the timer state and compares it field by field.
// Depends on hct_pkg for the item kinds, register indexes and reload constants.
module hct_reply_checker
    import hct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [23:0] i_in_data,  // reg_index[1:0], write_data[9:2], tick_count[15:10],
                                    // halted[16], zero fill
    input  logic [1:0]  i_in_user,  // kind[1:0]
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_out_data, // read_data[7:0], timer_irq[8], zero fill
    output int          o_fail_count,
    output int          o_pending
);

    localparam int MAX_TICKS = 32;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_irq;
    } t_reply;

    t_reply      replies[$];
    logic [15:0] div_count;
    logic [7:0]  counter;
    logic [7:0]  modulo;
    logic        enable;
    logic [1:0]  select;
    logic [7:0]  reload_wait;

    function automatic logic counter_edge(input logic [15:0] old_div, input logic [15:0] new_div);
        int b;
        if (!enable) begin
            return 1'b0;
        end
        case (select)
            2'd0:    b = 9;
            2'd1:    b = 3;
            2'd2:    b = 5;
            default: b = 7;
        endcase
        if (old_div[b] && !new_div[b]) begin
            if (counter == COUNTER_MAX) begin
                counter     = 8'd0;
                reload_wait = RELOAD_CYCLES;
                return 1'b1;
            end
            counter = counter + 8'd1;
        end
        return 1'b0;
    endfunction

    function automatic t_reply timer_reply(input logic [1:0] kind, input logic [1:0] idx,
                                           input logic [7:0] data, input logic [5:0] count,
                                           input logic halted);
        t_reply      r;
        int          n;
        logic [15:0] next_div;
        r = '0;
        case (kind)
            KIND_TICK: begin
                n = (count > MAX_TICKS) ? MAX_TICKS : int'(count);
                if (!halted) begin
                    for (int i = 0; i < n; i++) begin
                        if (reload_wait != NO_RELOAD) begin
                            reload_wait = reload_wait - 8'd1;
                            if (reload_wait == 8'd0) begin
                                counter     = modulo;
                                reload_wait = NO_RELOAD;
                            end
                        end
                        next_div = div_count + 16'd1;
                        if (counter_edge(div_count, next_div)) begin
                            r.timer_irq = 1'b1;
                        end
                        div_count = next_div;
                    end
                end
            end
            KIND_READ: begin
                case (idx)
                    REG_DIV: r.read_data = div_count[15:8];
                    REG_CNT: r.read_data = counter;
                    REG_MOD: r.read_data = modulo;
                    default: r.read_data = {5'd0, enable, select};
                endcase
            end
            KIND_WRITE: begin
                case (idx)
                    REG_DIV: begin
                        if (counter_edge(div_count, 16'd0)) begin
                            r.timer_irq = 1'b1;
                        end
                        div_count = 16'd0;
                    end
                    REG_CNT: begin
                        if (reload_wait != 8'd0) begin
                            counter = data;
                        end
                    end
                    REG_MOD: modulo = data;
                    default: begin
                        enable = data[2];
                        select = data[1:0];
                    end
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            div_count   = 16'd0;
            counter     = 8'd0;
            modulo      = 8'd0;
            enable      = 1'b0;
            select      = 2'd0;
            reload_wait = NO_RELOAD;
            replies.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (replies.size() == 0) begin
                    $error("unexpected result transfer: data %h", i_out_data);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = replies.pop_front();
                    if (i_out_data[7:0] !== want.read_data) begin
                        $error("read_data: expected %h, actual %h", want.read_data,
                               i_out_data[7:0]);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_out_data[8] !== want.timer_irq) begin
                        $error("timer_irq: expected %b, actual %b", want.timer_irq,
                               i_out_data[8]);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                replies.push_back(timer_reply(i_in_user, i_in_data[1:0], i_in_data[9:2],
                                              i_in_data[15:10], i_in_data[16]));
            end
        end
        o_pending = replies.size();
    end

endmodule

// ===== tb/sv/tb_handheld_console_timer_core.sv =====
// Top of the handheld console timer testbench: clock, reset, directed and random
// stimulus with random idling on both channels, and the final verdict.
// Depends on hct_pkg, handheld_console_timer_core and hct_reply_checker.
module tb_handheld_console_timer_core;
    import hct_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 950;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    int          fail_count;
    int          pending;
    int          send_calm;

    handheld_console_timer_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    hct_reply_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

    // Mostly random gaps, with occasional stretches of back-to-back transfers.
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0) begin
            calm_left = calm_left - 1;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    task automatic send_item(input logic [1:0] kind, input logic [1:0] idx,
                             input logic [7:0] data, input logic [5:0] count,
                             input logic halted);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {7'd0, halted, count, data, idx};
        s_axis_tuser  = kind;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic random_item;
        int         roll;
        logic [1:0] kind;
        logic [1:0] idx;
        logic [7:0] data;
        logic [5:0] count;
        logic       halted;
        roll   = $urandom_range(0, 99);
        idx    = 2'($urandom_range(0, 3));
        data   = 8'($urandom_range(0, 255));
        count  = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                             : 6'($urandom_range(1, 16));
        halted = ($urandom_range(0, 9) == 0);
        if (roll < 55) begin
            kind = KIND_TICK;
        end else if (roll < 72) begin
            kind = KIND_READ;
        end else if (roll < 96) begin
            kind = KIND_WRITE;
        end else begin
            kind = KIND_UNUSED;
        end
        if (kind == KIND_WRITE && idx == REG_DIV && $urandom_range(0, 3) != 0) begin
            idx = REG_MOD;
        end
        if (kind == KIND_WRITE && idx == REG_CNT && $urandom_range(0, 1) == 1) begin
            data = 8'($urandom_range(8'hF0, 8'hFF));
        end
        if (kind == KIND_WRITE && idx == REG_CTRL && $urandom_range(0, 2) != 0) begin
            data[2] = 1'b1;
        end
        send_item(kind, idx, data, count, halted);
    endtask

    initial begin
        int calm;
        int gap;
        int served;
        m_axis_tready = 1'b0;
        calm          = 0;
        served        = 0;
        wait (i_rst_n == 1'b1);
        @(negedge i_clk);
        forever begin
            if (served == HOLD_AFTER) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            gap = draw_gap(calm);
            if (gap > 0) begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            served = served + 1;
            @(negedge i_clk);
        end
    end

    initial begin
        int waited;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        send_calm     = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(KIND_READ, REG_DIV, 8'h00, 6'd0, 1'b0);
        send_item(KIND_READ, REG_CNT, 8'h00, 6'd0, 1'b0);
        send_item(KIND_READ, REG_MOD, 8'h00, 6'd0, 1'b0);
        send_item(KIND_READ, REG_CTRL, 8'h00, 6'd0, 1'b0);
        send_item(KIND_WRITE, REG_CTRL, 8'hFF, 6'd0, 1'b0);
        send_item(KIND_READ, REG_CTRL, 8'h00, 6'd0, 1'b0);
        send_item(KIND_WRITE, REG_MOD, 8'hAB, 6'd0, 1'b0);
        send_item(KIND_WRITE, REG_CTRL, 8'h05, 6'd0, 1'b0);
        send_item(KIND_WRITE, REG_DIV, 8'h00, 6'd0, 1'b0);
        send_item(KIND_WRITE, REG_CNT, 8'hFF, 6'd0, 1'b0);
        send_item(KIND_TICK, REG_DIV, 8'h00, 6'd8, 1'b0);
        // Clearing the divider with bit 3 set overflows the counter.
        send_item(KIND_WRITE, REG_DIV, 8'h00, 6'd0, 1'b0);
        send_item(KIND_WRITE, REG_CNT, 8'h12, 6'd0, 1'b0);
        send_item(KIND_READ, REG_CNT, 8'h00, 6'd0, 1'b0);
        send_item(KIND_TICK, REG_DIV, 8'h00, 6'd4, 1'b0);
        send_item(KIND_READ, REG_CNT, 8'h00, 6'd0, 1'b0);
        send_item(KIND_TICK, REG_DIV, 8'h00, 6'd63, 1'b0);
        send_item(KIND_TICK, REG_DIV, 8'h00, 6'd0, 1'b0);
        send_item(KIND_TICK, REG_CTRL, 8'hFF, 6'd32, 1'b1);
        send_item(KIND_UNUSED, REG_CTRL, 8'hFF, 6'd63, 1'b1);
        send_item(KIND_WRITE, REG_CTRL, 8'h00, 6'd0, 1'b0);
        send_item(KIND_TICK, REG_DIV, 8'h00, 6'd32, 1'b0);
        send_item(KIND_READ, REG_DIV, 8'h00, 6'd0, 1'b0);
        send_item(KIND_WRITE, REG_MOD, 8'h00, 6'd0, 1'b0);
        send_item(KIND_WRITE, REG_CTRL, 8'hFE, 6'd0, 1'b0);
        send_item(KIND_TICK, REG_DIV, 8'h00, 6'd32, 1'b0);

        repeat (RANDOM_ITEMS) random_item();
        s_axis_tvalid = 1'b0;

        for (waited = 0; waited < 5000 && pending != 0; waited++) begin
            @(negedge i_clk);
        end
        repeat (40) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
